/* src/itr_pkg.sv */
// ----------------------------------------------------------------------------
// itr_pkg: shared types and arithmetic for the 4x4 inverse transform
// Widths, block container type, butterfly and pixel reconstruction helpers.
// ----------------------------------------------------------------------------
package itr_pkg;

    localparam int COEF_BITS = 16;
    // row pass grows values by less than 4x, column pass again
    localparam int ROW_W     = COEF_BITS + 2;
    localparam int COL_W     = COEF_BITS + 4;
    localparam int RND       = 32;
    localparam int RND_SHIFT = 6;
    localparam int PIX_MAX   = 255;

    typedef logic signed [COL_W-1:0] wide_t;
    typedef logic [3:0][COL_W-1:0]   quad_t;

    typedef struct packed {
        logic [3:0][3:0][ROW_W-1:0] res;   // [row][col] row-transformed values
        logic [3:0][3:0][7:0]       pred;  // [row][col] prediction pixels
    } blk_t;

    // integer butterfly with half shifts
    function automatic quad_t butterfly(input quad_t x);
        wide_t e0;
        wide_t e1;
        wide_t e2;
        wide_t e3;
        quad_t y;
        e0 = $signed(x[0]) + $signed(x[2]);
        e1 = $signed(x[0]) - $signed(x[2]);
        e2 = ($signed(x[1]) >>> 1) - $signed(x[3]);
        e3 = $signed(x[1]) + ($signed(x[3]) >>> 1);
        y[0] = e0 + e3;
        y[1] = e1 + e2;
        y[2] = e1 - e2;
        y[3] = e0 - e3;
        return y;
    endfunction

    // round (+32 >>> 6), add prediction, clamp to 0..255
    function automatic logic [7:0] recon(input logic [COL_W-1:0] g, input logic [7:0] p);
        logic signed [COL_W:0] t;
        logic signed [COL_W:0] s;
        logic [7:0]            r;
        t = ($signed((COL_W+1)'($signed(g))) + (COL_W+1)'(RND)) >>> RND_SHIFT;
        s = t + $signed((COL_W+1)'(p));
        if (s < 0)
            r = 8'd0;
        else if (s > (COL_W+1)'(PIX_MAX))
            r = 8'(PIX_MAX);
        else
            r = s[7:0];
        return r;
    endfunction

endpackage

/* src/itr_front.sv */
// ----------------------------------------------------------------------------
// itr_front: row intake and horizontal transform
// Takes one coefficient row per transaction, runs the row butterfly and
// collects rows; the fourth row pushes a complete block into the queue.
// ----------------------------------------------------------------------------
module itr_front
    import itr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [3:0][COEF_BITS-1:0]  coef,
    input  logic [3:0][7:0]            pred,
    output logic                       push,
    output blk_t                       blk
);

    logic [1:0]                 rows_loaded_reg;
    logic [1:0]                 rows_loaded_next;
    logic [3:0][ROW_W-1:0]      row_reg  [3];
    logic [3:0][7:0]            pred_reg [3];
    quad_t                      x;
    quad_t                      y;
    logic [3:0][ROW_W-1:0]      row_y;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            x[i] = COL_W'($signed(coef[i]));
        end
        y = butterfly(x);
        for (int i = 0; i < 4; i++)
        begin
            row_y[i] = y[i][ROW_W-1:0];
        end
    end

    assign push             = accept && (rows_loaded_reg == 2'd3);
    assign rows_loaded_next = accept ? rows_loaded_reg + 2'd1 : rows_loaded_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            blk.res[r]  = row_reg[r];
            blk.pred[r] = pred_reg[r];
        end
        blk.res[3]  = row_y;
        blk.pred[3] = pred;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_loaded_reg <= 2'd0;
        else
            rows_loaded_reg <= rows_loaded_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (rows_loaded_reg != 2'd3))
        begin
            row_reg[rows_loaded_reg]  <= row_y;
            pred_reg[rows_loaded_reg] <= pred;
        end
    end

endmodule

/* src/itr_queue.sv */
// ----------------------------------------------------------------------------
// itr_queue: two-deep block queue
// Holds complete row-transformed blocks between intake and output.
// ----------------------------------------------------------------------------
module itr_queue
    import itr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  blk_t   wr_data,
    input  logic   pop,
    output blk_t   rd_data,
    output logic   full,
    output logic   nonempty
);

    blk_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

/* src/itr_back.sv */
// ----------------------------------------------------------------------------
// itr_back: vertical transform and reconstruction
// Pops a block, runs the four column butterflies, then emits one
// rounded, predicted and clamped pixel row per cycle.
// ----------------------------------------------------------------------------
module itr_back
    import itr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  blk_t                q_data,
    output logic                pop,
    output logic                row_valid,
    output logic [3:0][7:0]     pixel,
    output logic [1:0]          out_row,
    output logic                last_row
);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic                       valid_reg;
    logic [1:0]                 out_row_reg;
    logic                       last_row_reg;
    logic [3:0][7:0]            pixel_reg;
    logic [3:0][7:0]            pixel_next;
    logic [3:0][3:0][COL_W-1:0] col_reg;    // [row][col]
    logic [3:0][3:0][7:0]       pred_reg;
    logic [3:0][3:0][COL_W-1:0] col_next;
    quad_t                      cx;
    quad_t                      cy;

    // column butterflies on the queue head
    always_comb
    begin
        col_next = '0;
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cx[i] = COL_W'($signed(q_data.res[i][j]));
            end
            cy = butterfly(cx);
            for (int i = 0; i < 4; i++)
            begin
                col_next[i][j] = cy[i];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pixel_next[j] = recon(col_reg[cnt_reg][j], pred_reg[cnt_reg][j]);
        end
    end

    assign pop = q_nonempty && ((state_reg == ST_IDLE) || (cnt_reg == 2'd3));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = 2'd0;
                end
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg + 2'd1;
                if ((cnt_reg == 2'd3) && !pop)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 2'd0;
            valid_reg    <= 1'b0;
            out_row_reg  <= 2'd0;
            last_row_reg <= 1'b0;
            pixel_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            valid_reg    <= (state_reg == ST_EMIT);
            out_row_reg  <= cnt_reg;
            last_row_reg <= (state_reg == ST_EMIT) && (cnt_reg == 2'd3);
            pixel_reg    <= pixel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg  <= col_next;
            pred_reg <= q_data.pred;
        end
    end

    assign row_valid = valid_reg;
    assign pixel     = pixel_reg;
    assign out_row   = out_row_reg;
    assign last_row  = last_row_reg;

    // rows of one block leave on consecutive cycles, in order
    a_rows_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (out_row_reg != 2'd3)) |=>
            (valid_reg && (out_row_reg == 2'($past(out_row_reg) + 2'd1))))
        else $error("itr_back: block rows not consecutive");

    // a burst of rows always opens with row 0
    a_burst_starts_row0: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> (out_row_reg == 2'd0))
        else $error("itr_back: burst does not start at row 0");

    // last marker only and always on row 3
    a_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (last_row_reg == (out_row_reg == 2'd3)))
        else $error("itr_back: last_row mismatch");

    // never pop an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_nonempty)
        else $error("itr_back: pop on empty queue");

endmodule

/* src/inverse_transform_4x4_reconstruct.sv */
// ----------------------------------------------------------------------------
// inverse_transform_4x4_reconstruct: 4x4 inverse integer transform + recon
// Path: the fourth row of a block is written into the block queue, popped into
//   the column registers, then output rows 0..3 leave registered, in order.
// Throughput: one row transaction per cycle sustained while busy is low;
//   output drains a block row by row via the single row-reconstruct unit.
// busy rises only while both block queue slots are occupied.
// Reset clears the row counter, queue pointers and output strobe; stores are
//   undefined until written. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module inverse_transform_4x4_reconstruct
    import itr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_BITS-1:0]  coef_0,
    input  logic signed [COEF_BITS-1:0]  coef_1,
    input  logic signed [COEF_BITS-1:0]  coef_2,
    input  logic signed [COEF_BITS-1:0]  coef_3,
    input  logic [7:0]                   pred_pixel_0,
    input  logic [7:0]                   pred_pixel_1,
    input  logic [7:0]                   pred_pixel_2,
    input  logic [7:0]                   pred_pixel_3,
    output logic                         row_valid,
    output logic [7:0]                   pixel_0,
    output logic [7:0]                   pixel_1,
    output logic [7:0]                   pixel_2,
    output logic [7:0]                   pixel_3,
    output logic [1:0]                   out_row,
    output logic                         last_row
);

    // front/back handoff
    logic                       accept;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_nonempty;
    blk_t                       blk_in;
    blk_t                       blk_out;
    logic [3:0][COEF_BITS-1:0]  coef;
    logic [3:0][7:0]            pred;
    logic [3:0][7:0]            pixel;

    // A transaction is taken whenever the queue has room for a finished block.
    assign busy   = q_full;
    assign accept = start && !busy;

    assign coef = {coef_3, coef_2, coef_1, coef_0};
    assign pred = {pred_pixel_3, pred_pixel_2, pred_pixel_1, pred_pixel_0};

    // Intake: horizontal butterfly per row, block assembly
    itr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .coef   (coef),
        .pred   (pred),
        .push   (push),
        .blk    (blk_in)
    );

    // Two blocks of slack so intake never waits on the output burst
    itr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (blk_in),
        .pop      (pop),
        .rd_data  (blk_out),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    // Output: vertical butterfly, rounding, prediction add and clamp
    itr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (blk_out),
        .pop        (pop),
        .row_valid  (row_valid),
        .pixel      (pixel),
        .out_row    (out_row),
        .last_row   (last_row)
    );

    assign pixel_0 = pixel[0];
    assign pixel_1 = pixel[1];
    assign pixel_2 = pixel[2];
    assign pixel_3 = pixel[3];

endmodule

/* test/itr_recon_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itr_recon_checker: scoreboard for the 4x4 inverse transform block
// Watches row transactions in and pixel rows out, predicts each block's
// reconstructed rows and compares them field by field in order.
// ----------------------------------------------------------------------------
module itr_recon_checker
    import itr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [COEF_BITS-1:0] coef_0,
    input  logic signed [COEF_BITS-1:0] coef_1,
    input  logic signed [COEF_BITS-1:0] coef_2,
    input  logic signed [COEF_BITS-1:0] coef_3,
    input  logic [7:0]                  pred_pixel_0,
    input  logic [7:0]                  pred_pixel_1,
    input  logic [7:0]                  pred_pixel_2,
    input  logic [7:0]                  pred_pixel_3,
    input  logic                        row_valid,
    input  logic [7:0]                  pixel_0,
    input  logic [7:0]                  pixel_1,
    input  logic [7:0]                  pixel_2,
    input  logic [7:0]                  pixel_3,
    input  logic [1:0]                  out_row,
    input  logic                        last_row,
    output int                          mismatch_count,
    output int                          pending_rows
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [3:0][7:0] pix;
        logic [1:0]      row;
        logic            last;
    } pixel_row_t;

    logic signed [ROW_W-1:0] residue_rows [4][4];
    logic [7:0]              pred_rows    [4][4];
    logic [1:0]              rows_taken;
    pixel_row_t              expected_rows[$];

    // 4-point integer lifting with half shifts, 32-bit signed lanes
    function automatic logic [3:0][31:0] lift_4pt(input logic [3:0][31:0] x);
        int e0;
        int e1;
        int e2;
        int e3;
        logic [3:0][31:0] y;
        e0 = $signed(x[0]) + $signed(x[2]);
        e1 = $signed(x[0]) - $signed(x[2]);
        e2 = ($signed(x[1]) >>> 1) - $signed(x[3]);
        e3 = $signed(x[1]) + ($signed(x[3]) >>> 1);
        y[0] = e0 + e3;
        y[1] = e1 + e2;
        y[2] = e1 - e2;
        y[3] = e0 - e3;
        return y;
    endfunction

    function automatic logic [7:0] add_and_clamp(input int g, input logic [7:0] p);
        int s;
        s = ((g + 32) >>> 6) + int'(p);
        if (s < 0)
            return 8'd0;
        if (s > 255)
            return 8'd255;
        return s[7:0];
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [3:0][31:0] x;
        logic [3:0][31:0] y;
        pixel_row_t       want;
        pixel_row_t       blk_out[4];
        if (!rst_n) begin
            rows_taken   <= 2'd0;
            pending_rows <= 0;
            expected_rows.delete();
            mismatch_count = 0;
        end
        else begin
            // outgoing pixel rows: oldest expectation first
            if (row_valid) begin
                if (expected_rows.size() == 0) begin
                    note_mismatch("unexpected pixel row, out_row", -1, int'(out_row));
                end
                else begin
                    want = expected_rows.pop_front();
                    if (pixel_0 != want.pix[0]) note_mismatch("pixel_0", want.pix[0], pixel_0);
                    if (pixel_1 != want.pix[1]) note_mismatch("pixel_1", want.pix[1], pixel_1);
                    if (pixel_2 != want.pix[2]) note_mismatch("pixel_2", want.pix[2], pixel_2);
                    if (pixel_3 != want.pix[3]) note_mismatch("pixel_3", want.pix[3], pixel_3);
                    if (out_row != want.row) note_mismatch("out_row", want.row, out_row);
                    if (last_row != want.last) note_mismatch("last_row", want.last, last_row);
                end
            end
            // incoming coefficient row
            if (start && !busy) begin
                x[0] = int'(coef_0);
                x[1] = int'(coef_1);
                x[2] = int'(coef_2);
                x[3] = int'(coef_3);
                y = lift_4pt(x);
                for (int i = 0; i < 4; i++)
                    residue_rows[rows_taken][i] = y[i][ROW_W-1:0];
                pred_rows[rows_taken][0] = pred_pixel_0;
                pred_rows[rows_taken][1] = pred_pixel_1;
                pred_rows[rows_taken][2] = pred_pixel_2;
                pred_rows[rows_taken][3] = pred_pixel_3;
                if (rows_taken == 2'd3) begin
                    // column pass over the completed block
                    for (int j = 0; j < 4; j++) begin
                        for (int i = 0; i < 4; i++)
                            x[i] = int'(residue_rows[i][j]);
                        y = lift_4pt(x);
                        for (int i = 0; i < 4; i++)
                            blk_out[i].pix[j] = add_and_clamp($signed(y[i]), pred_rows[i][j]);
                    end
                    for (int i = 0; i < 4; i++) begin
                        blk_out[i].row  = 2'(i);
                        blk_out[i].last = (i == 3);
                        expected_rows.push_back(blk_out[i]);
                    end
                end
                rows_taken <= rows_taken + 2'd1;
            end
            pending_rows <= expected_rows.size();
        end
    end

endmodule

/* test/tb_inverse_transform_4x4_reconstruct.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_inverse_transform_4x4_reconstruct: testbench top
// Drives 4x4 coefficient blocks row by row (directed extremes, then random
// blocks with bursty idling and one full drain), lets the checker predict and
// compare the pixel rows, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_inverse_transform_4x4_reconstruct;
    import itr_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles tolerated, well above any legal gap
    localparam int DRAIN_CYCLES   = 8;     // pipeline registers plus a block's output rows, with margin
    localparam int RANDOM_BLOCKS  = 52;
    localparam int CALM_FIRST     = 10;    // blocks in [CALM_FIRST, CALM_LAST) run back to back
    localparam int CALM_LAST      = 16;
    localparam int HOLD_BLOCK     = 20;    // after this block the sender waits for a full drain
    localparam int QUIET_FROM     = 44;    // no idling from here to the end

    // coefficient flavors for random blocks
    localparam int MODE_SMALL   = 0;
    localparam int MODE_MEDIUM  = 1;
    localparam int MODE_FULL    = 2;
    localparam int MODE_EXTREME = 3;
    localparam int MODE_DC      = 4;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [COEF_BITS-1:0] coef_0;
    logic signed [COEF_BITS-1:0] coef_1;
    logic signed [COEF_BITS-1:0] coef_2;
    logic signed [COEF_BITS-1:0] coef_3;
    logic [7:0]                  pred_pixel_0;
    logic [7:0]                  pred_pixel_1;
    logic [7:0]                  pred_pixel_2;
    logic [7:0]                  pred_pixel_3;
    logic                        row_valid;
    logic [7:0]                  pixel_0;
    logic [7:0]                  pixel_1;
    logic [7:0]                  pixel_2;
    logic [7:0]                  pixel_3;
    logic [1:0]                  out_row;
    logic                        last_row;
    int                          mismatch_count;
    int                          pending_rows;
    int                          idle_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    inverse_transform_4x4_reconstruct uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coef_0       (coef_0),
        .coef_1       (coef_1),
        .coef_2       (coef_2),
        .coef_3       (coef_3),
        .pred_pixel_0 (pred_pixel_0),
        .pred_pixel_1 (pred_pixel_1),
        .pred_pixel_2 (pred_pixel_2),
        .pred_pixel_3 (pred_pixel_3),
        .row_valid    (row_valid),
        .pixel_0      (pixel_0),
        .pixel_1      (pixel_1),
        .pixel_2      (pixel_2),
        .pixel_3      (pixel_3),
        .out_row      (out_row),
        .last_row     (last_row)
    );

    // scoreboard sits beside the block and sees the same pins
    itr_recon_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .coef_0         (coef_0),
        .coef_1         (coef_1),
        .coef_2         (coef_2),
        .coef_3         (coef_3),
        .pred_pixel_0   (pred_pixel_0),
        .pred_pixel_1   (pred_pixel_1),
        .pred_pixel_2   (pred_pixel_2),
        .pred_pixel_3   (pred_pixel_3),
        .row_valid      (row_valid),
        .pixel_0        (pixel_0),
        .pixel_1        (pixel_1),
        .pixel_2        (pixel_2),
        .pixel_3        (pixel_3),
        .out_row        (out_row),
        .last_row       (last_row),
        .mismatch_count (mismatch_count),
        .pending_rows   (pending_rows)
    );

    // Watchdog: any accepted transaction on either side restarts the count.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end
        else if ((start && !busy) || row_valid) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("inverse_transform_4x4_reconstruct test failed");
                $finish;
            end
        end
    end

    function automatic logic [COEF_BITS-1:0] pick_coef(input int mode);
        case (mode)
            MODE_SMALL:   return COEF_BITS'($urandom_range(0, 80) - 40);
            MODE_MEDIUM:  return COEF_BITS'($urandom_range(0, 4000) - 2000);
            MODE_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return {1'b0, {(COEF_BITS-1){1'b1}}};  // most positive
                    1:       return {1'b1, {(COEF_BITS-1){1'b0}}};  // most negative
                    2:       return '1;                             // -1
                    default: return '0;
                endcase
            default:      return COEF_BITS'($urandom);
        endcase
    endfunction

    // Present one coefficient row and hold it until the block takes it.
    // busy is read right after the edge, i.e. the value the edge saw.
    task automatic send_row(input logic [3:0][COEF_BITS-1:0] c,
                            input logic [3:0][7:0] p,
                            input bit may_idle);
        int gap;
        start        <= 1'b1;
        coef_0       <= c[0];
        coef_1       <= c[1];
        coef_2       <= c[2];
        coef_3       <= c[3];
        pred_pixel_0 <= p[0];
        pred_pixel_1 <= p[1];
        pred_pixel_2 <= p[2];
        pred_pixel_3 <= p[3];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // occasional burst of idle cycles; lands after any row of a block
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    initial begin
        logic [3:0][COEF_BITS-1:0] c;
        logic [3:0][7:0]           p;
        logic [COEF_BITS-1:0]      cmax;
        logic [COEF_BITS-1:0]      cmin;
        int                        mode;

        cmax = {1'b0, {(COEF_BITS-1){1'b1}}};
        cmin = {1'b1, {(COEF_BITS-1){1'b0}}};

        rst_n        <= 1'b0;
        start        <= 1'b0;
        coef_0       <= '0;
        coef_1       <= '0;
        coef_2       <= '0;
        coef_3       <= '0;
        pred_pixel_0 <= '0;
        pred_pixel_1 <= '0;
        pred_pixel_2 <= '0;
        pred_pixel_3 <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed blocks ----
        // zero residual on black and on white prediction
        for (int r = 0; r < 4; r++)
            send_row('0, '0, 1'b0);
        for (int r = 0; r < 4; r++)
            send_row('0, {4{8'd255}}, 1'b0);
        // saturated residuals: full positive, then full negative, both clamps
        for (int r = 0; r < 4; r++)
            send_row({4{cmax}}, (r % 2) ? {4{8'd255}} : {4{8'd0}}, 1'b1);
        for (int r = 0; r < 4; r++)
            send_row({4{cmin}}, (r % 2) ? {4{8'd0}} : {4{8'd255}}, 1'b1);
        // checkerboard of extremes, alternating row phase
        for (int r = 0; r < 4; r++) begin
            c = (r % 2) ? {cmin, cmax, cmin, cmax} : {cmax, cmin, cmax, cmin};
            send_row(c, {8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0);
        end
        // small values: odd numbers exercise the half shifts and rounding
        send_row({48'd0, 16'sd64}, {4{8'd128}}, 1'b0);
        send_row({16'sd1, -16'sd1, 16'sd1, -16'sd1}, {4{8'd128}}, 1'b0);
        send_row({-16'sd3, 16'sd3, -16'sd33, 16'sd31}, {8'd1, 8'd254, 8'd0, 8'd255}, 1'b0);
        send_row({-16'sd32, 16'sd0, 16'sd0, 16'sd32}, {4{8'd128}}, 1'b0);

        // ---- random blocks ----
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            mode = $urandom_range(MODE_SMALL, MODE_DC);
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 4; k++) begin
                    if (mode == MODE_DC)
                        c[k] = (r == 0 && k == 0) ? pick_coef(MODE_MEDIUM) : '0;
                    else
                        c[k] = pick_coef(mode);
                    // bias some prediction pixels to the rails to hit clamping
                    if ($urandom_range(0, 7) == 0)
                        p[k] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    else
                        p[k] = 8'($urandom_range(0, 255));
                end
                send_row(c, p, (b < QUIET_FROM) && !(b >= CALM_FIRST && b < CALM_LAST)
                               && !(b == HOLD_BLOCK && r == 3));
            end
            // one full drain: sender waits until every expected row has come out
            if (b == HOLD_BLOCK) begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_rows != 0)
                    @(posedge clk);
            end
        end

        start <= 1'b0;
        while (pending_rows != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_rows == 0)
            $display("inverse_transform_4x4_reconstruct test passed");
        else
            $display("inverse_transform_4x4_reconstruct test failed");
        $finish;
    end

endmodule
